### rtl/stable_group_by_key_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef STABLE_GROUP_BY_KEY_MACROS_SVH
`define STABLE_GROUP_BY_KEY_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SGBK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that is checked during reset as well.
`define SGBK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/sgbk_pkg.sv
`timescale 1ns / 1ps
package sgbk_pkg;

    localparam int unsigned MaxGroupsDefault = 256;
    localparam int unsigned MaxPostsDefault  = 1024;

    localparam int unsigned KeyW  = 32;
    localparam int unsigned PostW = 20;
    localparam int unsigned GidxW = 8;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_FETCH = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_ADDED    = 2'd0,
        ST_FULL     = 2'd1,
        ST_RETURNED = 2'd2,
        ST_END      = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]       operation;
        logic [KeyW-1:0]  reply_id;
        logic [PostW-1:0] post_number;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [PostW-1:0] returned_post;
        logic [GidxW-1:0] group_index;
    } t_rsp;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_ADD,
        S_LINK,
        S_FETCH,
        S_FREAD,
        S_DONE
    } t_state;

    // Match result that the last cell hands back after a key sweep.
    typedef struct packed {
        logic hit;
        logic done;
    } t_srch;

endpackage

### rtl/sgbk_cell.sv
`timescale 1ns / 1ps
// One cell of the key chain: holds one stored key and compares it against
// the probe key that travels past it, one cell per cycle.
module sgbk_cell #(
    parameter int unsigned GW = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic [sgbk_pkg::KeyW-1:0] i_load_key,
    input  logic                      i_pv,
    input  logic [sgbk_pkg::KeyW-1:0] i_pkey,
    input  logic                      i_phit,
    input  logic [GW-1:0]             i_pidx,
    input  logic                      i_active,
    output logic                      o_pv,
    output logic [sgbk_pkg::KeyW-1:0] o_pkey,
    output logic                      o_phit,
    output logic [GW-1:0]             o_pidx,
    input  logic [GW-1:0]             i_my_idx
);
    logic [sgbk_pkg::KeyW-1:0] r_key;
    logic                      r_pv;
    logic [sgbk_pkg::KeyW-1:0] r_pkey;
    logic                      r_phit;
    logic [GW-1:0]             r_pidx;

    // Stored key is written when this cell's group is opened.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_key <= i_load_key;
        end
    end

    // Probe stage: the first matching active cell marks the hit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_pv;
        end
        r_pkey <= i_pkey;
        if (!i_phit && i_active && r_key == i_pkey) begin
            r_phit <= 1'b1;
            r_pidx <= i_my_idx;
        end else begin
            r_phit <= i_phit;
            r_pidx <= i_pidx;
        end
    end

    assign o_pv   = r_pv;
    assign o_pkey = r_pkey;
    assign o_phit = r_phit;
    assign o_pidx = r_pidx;
endmodule

### rtl/stable_group_by_key.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake            | Payload
// request  | in        | start high, busy low | i_req (t_req)
// result   | out       | o_done for one cycle | o_rsp (t_rsp)
//
// An add sends its key down a chain of MAX_GROUPS cells, one cell a cycle, then writes the post
// in S_ADD and the link in S_LINK; its result strobe comes in S_DONE, and the next request can
// be taken once the block is back in S_IDLE.
// A fetch reads the group entry, then the post, before it answers; a clear answers straight
// from idle, with no memory step.
// Reset is synchronous and active low; it clears counters and the walk.
// The result is not held: the receiver takes it in its single strobe cycle.
module stable_group_by_key #(
    parameter int unsigned MAX_GROUPS = sgbk_pkg::MaxGroupsDefault,
    parameter int unsigned MAX_POSTS  = sgbk_pkg::MaxPostsDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  sgbk_pkg::t_req  i_req,
    output logic            o_done,
    output sgbk_pkg::t_rsp  o_rsp
);
    localparam int unsigned GW  = $clog2(MAX_GROUPS);
    localparam int unsigned PW  = $clog2(MAX_POSTS);
    localparam int unsigned GCW = $clog2(MAX_GROUPS + 1);
    localparam int unsigned PCW = $clog2(MAX_POSTS + 1);
    localparam int unsigned KW  = sgbk_pkg::KeyW;
    localparam int unsigned NW  = sgbk_pkg::PostW;
    localparam int unsigned XW  = sgbk_pkg::GidxW;

    sgbk_pkg::t_state r_state, n_state;

    logic [KW-1:0]  r_key;
    logic [NW-1:0]  r_num;
    logic [GCW-1:0] r_groups_used;
    logic [PCW-1:0] r_posts_used;
    logic [GCW-1:0] r_fetch_group;
    logic [PW-1:0]  r_fetch_post;
    logic           r_fetch_started;
    logic [GW-1:0]  r_g;
    logic           r_new;

    // Memories.
    logic [PW-1:0] m_first [MAX_GROUPS];
    logic [PW-1:0] m_last  [MAX_GROUPS];
    logic [NW-1:0] m_num   [MAX_POSTS];
    logic [PW-1:0] m_link  [MAX_POSTS];
    logic [PW-1:0] r_first_q, r_last_q, r_link_q;
    logic [NW-1:0] r_num_q;

    // Key chain.
    logic          c_pv   [MAX_GROUPS+1];
    logic [KW-1:0] c_pkey [MAX_GROUPS+1];
    logic          c_phit [MAX_GROUPS+1];
    logic [GW-1:0] c_pidx [MAX_GROUPS+1];

    logic         s_accept;
    sgbk_pkg::t_srch s_srch;
    sgbk_pkg::t_rsp  r_rsp;
    logic            r_done;

    assign s_accept = start && !busy;
    assign s_srch.done = c_pv[MAX_GROUPS];
    assign s_srch.hit  = c_phit[MAX_GROUPS];

    assign c_pv[0]   = s_accept && i_req.operation == sgbk_pkg::OP_ADD;
    assign c_pkey[0] = i_req.reply_id;
    assign c_phit[0] = 1'b0;
    assign c_pidx[0] = '0;

    for (genvar gi = 0; gi < MAX_GROUPS; gi++) begin : g_cell
        sgbk_cell #(.GW(GW)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_load    (r_state == sgbk_pkg::S_ADD && r_new
                        && r_rsp.status == sgbk_pkg::ST_ADDED && r_g == GW'(gi)),
            .i_load_key(r_key),
            .i_pv      (c_pv[gi]),
            .i_pkey    (c_pkey[gi]),
            .i_phit    (c_phit[gi]),
            .i_pidx    (c_pidx[gi]),
            .i_active  (GCW'(gi) < r_groups_used),
            .o_pv      (c_pv[gi+1]),
            .o_pkey    (c_pkey[gi+1]),
            .o_phit    (c_phit[gi+1]),
            .o_pidx    (c_pidx[gi+1]),
            .i_my_idx  (GW'(gi))
        );
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sgbk_pkg::S_IDLE: begin
                if (s_accept) begin
                    case (i_req.operation)
                        sgbk_pkg::OP_ADD:   n_state = sgbk_pkg::S_SEARCH;
                        sgbk_pkg::OP_FETCH: n_state = sgbk_pkg::S_FETCH;
                        sgbk_pkg::OP_CLEAR: n_state = sgbk_pkg::S_DONE;
                        default:            n_state = sgbk_pkg::S_IDLE;
                    endcase
                end
            end
            sgbk_pkg::S_SEARCH: if (s_srch.done) n_state = sgbk_pkg::S_ADD;
            sgbk_pkg::S_ADD:    n_state = sgbk_pkg::S_LINK;
            sgbk_pkg::S_LINK:   n_state = sgbk_pkg::S_DONE;
            sgbk_pkg::S_FETCH:  n_state = sgbk_pkg::S_FREAD;
            sgbk_pkg::S_FREAD:  n_state = sgbk_pkg::S_DONE;
            sgbk_pkg::S_DONE:   n_state = sgbk_pkg::S_IDLE;
            default:            n_state = sgbk_pkg::S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        busy = r_state != sgbk_pkg::S_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sgbk_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_key <= i_req.reply_id;
            r_num <= i_req.post_number;
        end
    end

    // Group entries are read at the fetch group while idle or fetching, else at r_g.
    logic [GW-1:0] s_rg;
    always_comb begin
        s_rg = r_g;
        if (r_state inside {sgbk_pkg::S_IDLE, sgbk_pkg::S_FETCH, sgbk_pkg::S_FREAD}) begin
            s_rg = r_fetch_group[GW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_q <= m_first[s_rg];
        r_last_q  <= m_last[s_rg];
    end

    // Fetch walk pointer after the group read.
    logic [PW-1:0] s_fp;
    assign s_fp = r_fetch_started ? r_fetch_post : r_first_q;

    always_ff @(posedge i_clk) begin
        r_num_q  <= m_num[s_fp];
        r_link_q <= m_link[s_fp];
    end

    // Memory writes. In S_LINK r_last_q still holds the group's old tail.
    always_ff @(posedge i_clk) begin
        if (r_state == sgbk_pkg::S_ADD && r_rsp.status == sgbk_pkg::ST_ADDED) begin
            m_num[r_posts_used[PW-1:0]]  <= r_num;
            m_last[r_g]                  <= r_posts_used[PW-1:0];
            if (r_new) begin
                m_first[r_g] <= r_posts_used[PW-1:0];
            end
        end
        if (r_state == sgbk_pkg::S_LINK && r_rsp.status == sgbk_pkg::ST_ADDED && !r_new) begin
            m_link[r_last_q] <= r_posts_used[PW-1:0] - PW'(1);
        end
    end

    logic s_full;
    assign s_full = r_posts_used >= PCW'(MAX_POSTS)
                 || (!s_srch.hit && r_groups_used >= GCW'(MAX_GROUPS));

    // Result strobe: registered in the cycle after the last step of each request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_state inside {sgbk_pkg::S_LINK, sgbk_pkg::S_FREAD}
                   || (s_accept && i_req.operation == sgbk_pkg::OP_CLEAR);
        end
    end

    // Main control and results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_groups_used   <= '0;
            r_posts_used    <= '0;
            r_fetch_group   <= '0;
            r_fetch_post    <= '0;
            r_fetch_started <= 1'b0;
            r_rsp           <= '0;
        end else begin
            case (r_state)
                sgbk_pkg::S_IDLE: begin
                    if (s_accept && i_req.operation == sgbk_pkg::OP_CLEAR) begin
                        r_groups_used   <= '0;
                        r_posts_used    <= '0;
                        r_fetch_group   <= '0;
                        r_fetch_post    <= '0;
                        r_fetch_started <= 1'b0;
                        r_rsp           <= '0;
                    end
                end
                sgbk_pkg::S_SEARCH: begin
                    if (s_srch.done) begin
                        r_new <= !s_srch.hit;
                        r_g   <= s_srch.hit ? c_pidx[MAX_GROUPS]
                                            : r_groups_used[GW-1:0];
                        r_rsp.returned_post <= '0;
                        if (s_full) begin
                            r_rsp.status      <= sgbk_pkg::ST_FULL;
                            r_rsp.group_index <= '0;
                        end else begin
                            r_rsp.status      <= sgbk_pkg::ST_ADDED;
                            r_rsp.group_index <= s_srch.hit
                                ? XW'(c_pidx[MAX_GROUPS]) : XW'(r_groups_used);
                        end
                    end
                end
                sgbk_pkg::S_ADD: begin
                    if (r_rsp.status == sgbk_pkg::ST_ADDED) begin
                        r_posts_used <= r_posts_used + PCW'(1);
                        if (r_new) begin
                            r_groups_used <= r_groups_used + GCW'(1);
                        end
                    end
                end
                sgbk_pkg::S_FETCH: begin
                    // Group entries for fetch_group were read in the idle cycle.
                end
                sgbk_pkg::S_FREAD: begin
                    if (r_fetch_group >= r_groups_used) begin
                        r_rsp.status        <= sgbk_pkg::ST_END;
                        r_rsp.returned_post <= '0;
                        r_rsp.group_index   <= '0;
                    end else begin
                        r_rsp.status        <= sgbk_pkg::ST_RETURNED;
                        r_rsp.returned_post <= r_num_q;
                        r_rsp.group_index   <= XW'(r_fetch_group);
                        if (s_fp == r_last_q) begin
                            r_fetch_group   <= r_fetch_group + GCW'(1);
                            r_fetch_started <= 1'b0;
                            r_fetch_post    <= '0;
                        end else begin
                            r_fetch_started <= 1'b1;
                            r_fetch_post    <= r_link_q;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;
endmodule

### rtl/sgbk_checker.sv
`timescale 1ns / 1ps
`include "stable_group_by_key_macros.svh"
// Port-level checks of the command channel and its results.
module sgbk_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input sgbk_pkg::t_req i_req,
    input logic           o_done,
    input sgbk_pkg::t_rsp o_rsp
);
    // A result strobe lasts one cycle.
    `SGBK_ASSERT(a_done_pulse, i_clk, i_rst_n, o_done |=> !o_done, "result strobe held")
    // An end-of-walk result carries a zero post number.
    `SGBK_ASSERT(a_end_zero, i_clk, i_rst_n,
        (o_done && o_rsp.status == sgbk_pkg::ST_END) |-> o_rsp.returned_post == '0,
        "end status with data")
    // An accepted real request makes the block busy.
    `SGBK_ASSERT(a_busy, i_clk, i_rst_n,
        (start && !busy && i_req.operation != sgbk_pkg::OP_NONE) |=> busy,
        "request not taken")
    // Reset leaves the block idle.
    `SGBK_ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !busy && !o_done, "not idle after reset")
endmodule

bind stable_group_by_key sgbk_checker u_sgbk_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .i_req  (i_req),
    .o_done (o_done),
    .o_rsp  (o_rsp)
);

### sim/stable_group_by_key_checker.sv
`timescale 1ns / 1ps
module stable_group_by_key_checker
    import sgbk_pkg::*;
#(
    parameter int unsigned MAX_GROUPS = MaxGroupsDefault,
    parameter int unsigned MAX_POSTS  = MaxPostsDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic busy,
    input  t_req i_req,
    input  logic o_done,
    input  t_rsp o_rsp,
    output int   o_errors,
    output int   o_pending,
    output int   o_full_seen,
    output int   o_returned_seen
);

    // Shadow copy of the grouping store.
    logic [KeyW-1:0]  key_of_group  [MAX_GROUPS];
    int unsigned      head_of_group [MAX_GROUPS];
    int unsigned      tail_of_group [MAX_GROUPS];
    logic [PostW-1:0] number_in_slot[MAX_POSTS];
    int unsigned      next_slot     [MAX_POSTS];
    int unsigned      groups_open;
    int unsigned      posts_held;
    int unsigned      walk_group;
    int unsigned      walk_slot;
    bit               walk_in_group;

    t_rsp expected_rsps[$];

    initial begin
        o_errors        = 0;
        o_full_seen     = 0;
        o_returned_seen = 0;
    end

    assign o_pending = expected_rsps.size();

    task automatic report(input string what, input t_rsp got, input t_rsp want);
        $display("%0t mismatch: %s got st=%0d post=%0h grp=%0d want st=%0d post=%0h grp=%0d",
                 $realtime, what, got.status, got.returned_post, got.group_index,
                 want.status, want.returned_post, want.group_index);
        o_errors++;
    endtask

    function automatic t_rsp make_rsp(t_status st, logic [PostW-1:0] num, int unsigned grp);
        t_rsp r;
        r.status        = st;
        r.returned_post = num;
        r.group_index   = grp[GidxW-1:0];
        return r;
    endfunction

    // Append a post to its group, opening the group on first sight of the key.
    function automatic t_rsp group_post(logic [KeyW-1:0] key, logic [PostW-1:0] num);
        int unsigned grp;
        int unsigned slot;
        grp = 0;
        while (grp < groups_open && key_of_group[grp] != key) grp++;
        if (posts_held >= MAX_POSTS || grp >= MAX_GROUPS) return make_rsp(ST_FULL, '0, 0);
        slot = posts_held;
        number_in_slot[slot] = num;
        next_slot[slot] = 0;
        posts_held++;
        if (grp >= groups_open) begin
            key_of_group[grp]  = key;
            head_of_group[grp] = slot;
            groups_open++;
        end else begin
            next_slot[tail_of_group[grp]] = slot;
        end
        tail_of_group[grp] = slot;
        return make_rsp(ST_ADDED, '0, grp);
    endfunction

    // Step the walk one post forward in first-appearance order.
    function automatic t_rsp next_grouped_post();
        int unsigned slot;
        t_rsp r;
        if (walk_group >= groups_open) return make_rsp(ST_END, '0, 0);
        if (!walk_in_group) begin
            walk_slot = head_of_group[walk_group];
            walk_in_group = 1'b1;
        end
        slot = walk_slot;
        r = make_rsp(ST_RETURNED, number_in_slot[slot], walk_group);
        if (slot == tail_of_group[walk_group]) begin
            walk_group++;
            walk_in_group = 1'b0;
            walk_slot = 0;
        end else begin
            walk_slot = next_slot[slot];
        end
        return r;
    endfunction

    // Compare finished results first, then predict for the request taken at this edge.
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            groups_open = 0;
            posts_held = 0;
            walk_group = 0;
            walk_slot = 0;
            walk_in_group = 1'b0;
        end else begin
            if (o_done) begin
                if (expected_rsps.size() == 0) begin
                    report("unexpected result", o_rsp, '0);
                end else begin
                    want = expected_rsps.pop_front();
                    if (o_rsp.status != want.status) report("status", o_rsp, want);
                    else if (o_rsp.returned_post != want.returned_post)
                        report("returned_post", o_rsp, want);
                    else if (o_rsp.group_index != want.group_index)
                        report("group_index", o_rsp, want);
                    if (o_rsp.status == ST_FULL) o_full_seen++;
                    if (o_rsp.status == ST_RETURNED) o_returned_seen++;
                end
            end
            if (start && !busy) begin
                case (t_op'(i_req.operation))
                    OP_ADD: expected_rsps.push_back(group_post(i_req.reply_id,
                                                               i_req.post_number));
                    OP_FETCH: expected_rsps.push_back(next_grouped_post());
                    OP_CLEAR: begin
                        groups_open = 0;
                        posts_held = 0;
                        walk_group = 0;
                        walk_slot = 0;
                        walk_in_group = 1'b0;
                        expected_rsps.push_back(make_rsp(ST_ADDED, '0, 0));
                    end
                    default: ;
                endcase
            end
        end
    end

    // Report whatever is still owed once the run is over.
    task automatic flush_leftovers();
        while (expected_rsps.size() > 0) report("missing result", '0, expected_rsps.pop_front());
    endtask

endmodule

### sim/stable_group_by_key_tb.sv
`timescale 1ns / 1ps
module stable_group_by_key_tb;
    import sgbk_pkg::*;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_rsp o_rsp;
    int   errors;
    int   pending;
    int   full_seen;
    int   returned_seen;

    int          idle_pct;
    int          requests_sent;
    int          adds_sent;
    int          fetches_sent;
    int          clears_sent;
    logic [31:0] key_pool[8];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    stable_group_by_key dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    stable_group_by_key_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (i_req),
        .o_done         (o_done),
        .o_rsp          (o_rsp),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_full_seen    (full_seen),
        .o_returned_seen(returned_seen)
    );

    // Present one request and hold it until the block takes it.
    task automatic send(input t_op op, input logic [31:0] key, input logic [19:0] num);
        if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_req.operation   <= op;
        i_req.reply_id    <= key;
        i_req.post_number <= num;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        requests_sent++;
        case (op)
            OP_ADD:   adds_sent++;
            OP_FETCH: fetches_sent++;
            OP_CLEAR: clears_sent++;
            default:  ;
        endcase
    endtask

    // Hold off until every result owed has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_key();
        if ($urandom_range(9, 0) == 0) return $urandom();
        return key_pool[$urandom_range(7, 0)];
    endfunction

    // Mixed traffic over a small key pool so groups interleave with the walk.
    task automatic mixed_burst(input int count);
        int roll;
        foreach (key_pool[k]) key_pool[k] = $urandom();
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99, 0);
            if (roll < 55) send(OP_ADD, pick_key(), 20'($urandom()));
            else if (roll < 93) send(OP_FETCH, $urandom(), 20'($urandom()));
            else if (roll < 97) send(OP_CLEAR, $urandom(), 20'($urandom()));
            else send(OP_NONE, $urandom(), 20'($urandom()));
        end
    endtask

    initial begin
        int episode;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_pct = 0;

        // Directed: key and post extremes, walk order, end of walk, late adds.
        send(OP_ADD, 32'h0, 20'h0);
        send(OP_ADD, 32'hFFFF_FFFF, 20'hF_FFFF);
        send(OP_ADD, 32'h0, 20'h5);
        repeat (4) send(OP_FETCH, '0, '0);
        send(OP_ADD, 32'h7, 20'hA_AAAA);
        send(OP_FETCH, 32'hFFFF_FFFF, 20'hF_FFFF);
        send(OP_ADD, 32'h0, 20'h5_5555);
        send(OP_FETCH, '0, '0);
        send(OP_NONE, 32'hFFFF_FFFF, 20'hF_FFFF);
        send(OP_FETCH, '0, '0);
        send(OP_CLEAR, 32'hFFFF_FFFF, 20'hF_FFFF);
        send(OP_FETCH, '0, '0);
        // A post appended to the group under the walk comes out in its turn.
        send(OP_ADD, 32'h1234_5678, 20'h1);
        send(OP_ADD, 32'h1234_5678, 20'h2);
        send(OP_FETCH, '0, '0);
        send(OP_ADD, 32'h1234_5678, 20'h3);
        send(OP_FETCH, '0, '0);
        send(OP_FETCH, '0, '0);
        send(OP_FETCH, '0, '0);
        drain();

        // Random episodes, cycling through the idle settings.
        episode = 0;
        while (requests_sent < 1700) begin
            case (episode % 4)
                0: idle_pct = 0;
                1: idle_pct = 50;
                2: idle_pct = 0;
                default: idle_pct = 20;
            endcase
            if (episode == 2) begin
                // Open more groups than the store holds.
                send(OP_CLEAR, '0, '0);
                for (int n = 0; n < MaxGroupsDefault + 4; n++)
                    send(OP_ADD, {16'($urandom_range(16'hFFFF, 0)), n[15:0]},
                         20'($urandom()));
                repeat (20) send(OP_FETCH, '0, '0);
            end else if (episode == 5) begin
                // Fill the post store through a handful of groups.
                send(OP_CLEAR, '0, '0);
                foreach (key_pool[k]) key_pool[k] = $urandom();
                for (int n = 0; n < MaxPostsDefault + 6; n++)
                    send(OP_ADD, key_pool[$urandom_range(3, 0)], 20'($urandom()));
                repeat (30) send(OP_FETCH, '0, '0);
            end else begin
                mixed_burst(60);
            end
            if (episode % 3 == 1) drain();
            episode++;
        end

        drain();
        repeat (600) @(posedge i_clk);
        chk.flush_leftovers();
        $display("Sent %0d requests: %0d adds, %0d fetches, %0d clears.",
                 requests_sent, adds_sent, fetches_sent, clears_sent);
        $display("Saw %0d posts returned and %0d adds refused for a full store.",
                 returned_seen, full_seen);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        requests_sent = 0;
        adds_sent     = 0;
        fetches_sent  = 0;
        clears_sent   = 0;
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/sgbk_pkg.sv
rtl/sgbk_cell.sv
rtl/stable_group_by_key.sv
rtl/sgbk_checker.sv
sim/stable_group_by_key_checker.sv
sim/stable_group_by_key_tb.sv
